// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the glyph pixel unpacker.
// Needs clock aclk and active-low reset aresetn in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define PGPU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define PGPU_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);
`else
`define PGPU_ASSERT(lbl, prop, msg)
`define PGPU_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

// File: src/pgpu_pkg.sv
// Package of the glyph pixel unpacker: depth codes, register indexes and
// the structs passed between the byte stage and the pixel stage. No dependencies.
package pgpu_pkg;

    localparam int unsigned CNT_W = 16;

    typedef enum logic [1:0] {
        DEPTH_1BPP = 2'd0,
        DEPTH_2BPP = 2'd1,
        DEPTH_4BPP = 2'd2,
        DEPTH_RSVD = 2'd3
    } depth_mode_t;

    typedef enum logic [1:0] {
        REG_DEPTH_MODE  = 2'd0,
        REG_ROW_WIDTH   = 2'd1,
        REG_GLYPH_TOTAL = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_index_t;

    typedef struct packed {
        depth_mode_t      depth_mode;
        logic [CNT_W-1:0] row_width;
        logic [CNT_W-1:0] glyph_total;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       start;
        logic [2:0] idx;
    } byte_stage_t;

    typedef struct packed {
        logic fire;
        logic done;
    } pix_fb_t;

endpackage

// File: src/pgpu_byte_stage.sv
// Input register of the glyph pixel unpacker: holds the current packed word
// and the index of the next pixel in it. Depends on pgpu_pkg.
module pgpu_byte_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] packed_byte
    input  logic [0:0]            s_tuser,   // [0] glyph_start
    input  pgpu_pkg::pix_fb_t     fb,
    output pgpu_pkg::byte_stage_t stage
);
    import pgpu_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       start_reg, start_next;
    logic [2:0] idx_reg, idx_next;
    logic       load;

    assign s_tready = !valid_reg || (fb.fire && fb.done);
    assign load     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        start_next = start_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = s_tdata;
            start_next = s_tuser[0];
            idx_next   = 3'd0;
        end else if (fb.fire) begin
            valid_next = !fb.done;
            start_next = 1'b0;
            idx_next   = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg  <= data_next;
        start_reg <= start_next;
        idx_reg   <= idx_next;
    end

    assign stage = '{valid: valid_reg, data: data_reg, start: start_reg, idx: idx_reg};

endmodule

// File: src/pgpu_pixel_stage.sv
// Pixel stage of the glyph pixel unpacker: selects one pixel, keeps the row
// and glyph counters and holds the result register. Depends on pgpu_pkg.
module pgpu_pixel_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pgpu_pkg::cfg_t        cfg,
    input  pgpu_pkg::byte_stage_t stage,
    output pgpu_pkg::pix_fb_t     fb,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [3:0] pixel_value, [7:4] zero
    output logic                  m_tlast,   // glyph_last
    output logic [0:0]            m_tuser    // [0] byte_last
);
    import pgpu_pkg::*;
    `include "assert_macros.svh"

    localparam logic [CNT_W-1:0] GLYPH_TOTAL_RST = CNT_W'(64);

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             mvalid_reg, mvalid_next;
    logic [3:0]       pix_reg, pix_next;
    logic             blast_reg, blast_next;
    logic             glast_reg, glast_next;

    logic             fire;
    logic [CNT_W-1:0] col_base, left_base, col_inc;
    logic             row_end, glyph_end, last;
    logic [2:0]       last_idx;
    logic [2:0]       shamt;
    logic [7:0]       shifted;
    logic [3:0]       value;

    assign fire = stage.valid && (!mvalid_reg || m_tready);

    always_comb begin
        unique case (cfg.depth_mode)
            DEPTH_1BPP: begin
                last_idx = 3'd7;
                shamt    = stage.idx;
            end
            DEPTH_2BPP: begin
                last_idx = 3'd3;
                shamt    = {stage.idx[1:0], 1'b0};
            end
            default: begin
                last_idx = 3'd1;
                shamt    = {stage.idx[0], 2'b00};
            end
        endcase
        shifted = stage.data << shamt;
        unique case (cfg.depth_mode)
            DEPTH_1BPP: value = {3'b000, shifted[7]};
            DEPTH_2BPP: value = {2'b00, shifted[7:6]};
            default:    value = shifted[7:4];
        endcase
    end

    assign col_base  = stage.start ? '0 : col_reg;
    assign left_base = stage.start ? cfg.glyph_total : left_reg;
    assign col_inc   = col_base + CNT_W'(1);
    assign row_end   = (col_inc == cfg.row_width);
    assign glyph_end = (left_base == CNT_W'(1));
    assign last      = (stage.idx == last_idx) || row_end || glyph_end;

    always_comb begin
        col_next    = col_reg;
        left_next   = left_reg;
        mvalid_next = mvalid_reg;
        pix_next    = pix_reg;
        blast_next  = blast_reg;
        glast_next  = glast_reg;
        if (fire) begin
            if (glyph_end) begin
                col_next  = '0;
                left_next = cfg.glyph_total;
            end else begin
                col_next  = row_end ? '0 : col_inc;
                left_next = left_base - CNT_W'(1);
            end
            mvalid_next = 1'b1;
            pix_next    = value;
            blast_next  = last;
            glast_next  = glyph_end;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            left_reg   <= GLYPH_TOTAL_RST;
            mvalid_reg <= 1'b0;
        end else begin
            col_reg    <= col_next;
            left_reg   <= left_next;
            mvalid_reg <= mvalid_next;
        end
        pix_reg   <= pix_next;
        blast_reg <= blast_next;
        glast_reg <= glast_next;
    end

    assign fb         = '{fire: fire, done: last};
    assign m_tvalid   = mvalid_reg;
    assign m_tdata    = {4'b0000, pix_reg};
    assign m_tlast    = glast_reg;
    assign m_tuser[0] = blast_reg;

    `PGPU_ASSERT(a_glyph_ends_word, !mvalid_reg || !glast_reg || blast_reg, "glyph end without word end")
    `PGPU_ASSERT_NEXT(a_fire_loads_result, fire, mvalid_reg, "pixel lost on its way to the result")
    `PGPU_ASSERT_NEXT(a_glyph_rewinds, fire && glyph_end, col_reg == '0, "column count not rewound")
    `PGPU_ASSERT(a_start_on_first, !stage.valid || stage.idx == 3'd0 || !stage.start, "rewind seen after first pixel")

endmodule

// File: src/packed_glyph_pixel_unpacker_core.sv
// Top level of the glyph pixel unpacker: configuration registers, byte stage
// and pixel stage. Depends on pgpu_pkg, pgpu_byte_stage and pgpu_pixel_stage.
//
// Packed bitmap words arrive on the s_ channel (tdata carries the byte, tuser[0]
// rewinds the row and glyph counters before that byte). Each word yields one to
// eight pixels on the m_ channel, most significant pixel first, one per cycle while
// the receiver is ready: tdata[3:0] is the pixel, tuser[0] marks the last pixel taken
// from the word and tlast marks the final pixel of the glyph.
// The first pixel of a word passes through the byte stage register and then the
// result register. A word yields eight pixels at one bit per pixel, four at two,
// two at four and fewer at a row or glyph end, and the next word is taken in the
// cycle its last pixel moves to the result register, so pixels leave back to back
// at one per cycle while the receiver is ready.
// When the receiver stalls, the result register holds its pixel and the word
// in the selector waits; nothing is dropped. Reset sets one bit per pixel, rows
// of 8 and glyphs of 64 pixels, clears both channels and rewinds the counters.
// Registers are written through cfg_wr_en, cfg_index and cfg_data, one per cycle;
// the user must write them only while no word is in flight (not enforced here).
module packed_glyph_pixel_unpacker_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] packed_byte
    input  logic [0:0]  s_tuser,   // [0] glyph_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] pixel_value, [7:4] zero
    output logic        m_tlast,   // glyph_last
    output logic [0:0]  m_tuser    // [0] byte_last
);
    import pgpu_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    byte_stage_t stage;
    pix_fb_t     fb;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_index))
                REG_DEPTH_MODE:  cfg_next.depth_mode  = depth_mode_t'(cfg_data[1:0]);
                REG_ROW_WIDTH:   cfg_next.row_width   = cfg_data;
                REG_GLYPH_TOTAL: cfg_next.glyph_total = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{depth_mode: DEPTH_1BPP, row_width: CNT_W'(8),
                         glyph_total: CNT_W'(64)};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pgpu_byte_stage u_byte_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .fb       (fb),
        .stage    (stage)
    );

    pgpu_pixel_stage u_pixel_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .stage    (stage),
        .fb       (fb),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
